FILE: design/dsdl_pkg.sv
// Shared types, constants and helper functions for the depth-sorted draw list.
// No dependencies; the top, the sequencer and the datapath import this package.
package dsdl_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 16;
    localparam int MAX_OUT  = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic signed [KEY_BITS-1:0] t_key;
    typedef logic [IDX_W-1:0]           t_idx;
    typedef logic [CNT_W-1:0]           t_cnt;
    typedef logic [CAPACITY-1:0]        t_vec;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_DUMP   = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_APPLY,
        S_REM_CMP,
        S_REM_DEL,
        S_REM_EMIT,
        S_DUMP
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_INS_CMP,
        DP_INS_APPLY,
        DP_REM_CMP,
        DP_REM_DEL,
        DP_EMIT_FULL,
        DP_EMIT_REM,
        DP_DUMP_EMIT,
        DP_EMIT_EMPTY
    } t_dp_op;

    typedef struct packed {
        logic full;       // list holds CAPACITY entries
        logic empty;      // list holds no entry
        logic any_match;  // registered match vector has a hit
        logic dump_last;  // current dump index is the final one
        logic out_free;   // output register can take a beat this cycle
    } t_dp_stat;

    // Sign-extend the 16-bit field and clamp it to the KEY_BITS range.
    function automatic t_key sat_key(logic signed [15:0] raw);
        logic signed [32:0] v;
        logic signed [32:0] hi;
        logic signed [32:0] lo;
        v  = 33'(raw);
        hi = (33'sd1 <<< (KEY_BITS - 1)) - 33'sd1;
        lo = -hi - 33'sd1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[KEY_BITS-1:0];
    endfunction

    // Key back to the 16-bit output field.
    function automatic logic [15:0] key_field(t_key k);
        logic signed [32:0] e;
        e = 33'(k);
        return e[15:0];
    endfunction

    // Lowest set bit index; zero when no bit is set.
    function automatic t_idx first_set(t_vec v);
        t_idx r;
        r = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (v[i]) r = IDX_W'(i);
        end
        return r;
    endfunction

endpackage

FILE: design/dsdl_in_if.sv
// Command channel: action, handle and depth with valid/ready.
// Depends on nothing.
interface dsdl_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  handle;
    logic signed [15:0] depth_key;

    modport source (output valid, action, handle, depth_key, input ready);
    modport sink   (input valid, action, handle, depth_key, output ready);
endinterface

FILE: design/dsdl_out_if.sv
// Result channel: one beat per list report, with valid/ready.
// Depends on nothing.
interface dsdl_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  out_handle;
    logic signed [15:0] out_depth;
    logic [3:0]  position;
    logic        last;
    logic [4:0]  entry_count;

    modport source (output valid, status, out_handle, out_depth, position, last,
                    entry_count, input ready);
    modport sink   (input valid, status, out_handle, out_depth, position, last,
                    entry_count, output ready);
endinterface

FILE: design/depth_sorted_draw_list_top.sv
// Depth-sorted draw list, top level. After the accept, insert registers its compare vector and
// then loads its beat (a full list loads a FULL beat instead); remove loops compare/delete once
// per match and then loads its beat; dump loads one beat per cycle while the output is free.
// One command at a time; a new command is taken the cycle after the previous one's last beat is loaded.
// Reset (i_rst_n, synchronous, active low) empties the list and clears the sequencer and
// the output valid; slot contents are not cleared and are never read above the fill count.
module depth_sorted_draw_list_top import dsdl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dsdl_in_if.sink   i_in,
    dsdl_out_if.source o_out
);

    // command/status link between sequencer and datapath
    t_dp_op   dp_op;
    t_dp_stat dp_stat;
    logic     in_ready;

    // Sequencer: one command in flight. Insert checks for a full list, registers
    // the depth compare vector, then shifts the tail and writes the new slot.
    // Remove loops compare/delete, dropping the lowest match each pass.
    // Dump walks slot indices, one beat per cycle while the sink keeps up.
    dsdl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_action   (i_in.action),
        .i_stat     (dp_stat),
        .o_in_ready (in_ready),
        .o_op       (dp_op)
    );

    assign i_in.ready = in_ready;

    // Datapath: slot registers, compare vectors and the output register that
    // holds a finished beat until the sink takes it.
    dsdl_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (dp_op),
        .i_handle    (i_in.handle),
        .i_depth_key (i_in.depth_key),
        .o_stat      (dp_stat),
        .o_out       (o_out)
    );

endmodule

FILE: design/dsdl_ctrl.sv
// Sequencer for insert, remove and dump; issues datapath commands.
// Depends on dsdl_pkg.
module dsdl_ctrl import dsdl_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic [1:0] i_action,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_op   o_op
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_op       = DP_NOP;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op = DP_LOAD;
                    case (t_action'(i_action))
                        ACT_INSERT: n_state = S_INS_CMP;
                        ACT_REMOVE: n_state = S_REM_CMP;
                        ACT_DUMP:   n_state = S_DUMP;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_INS_CMP: begin
                if (i_stat.full) begin
                    if (i_stat.out_free) begin
                        o_op    = DP_EMIT_FULL;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_op    = DP_INS_CMP;
                    n_state = S_INS_APPLY;
                end
            end
            S_INS_APPLY: begin
                if (i_stat.out_free) begin
                    o_op    = DP_INS_APPLY;
                    n_state = S_IDLE;
                end
            end
            S_REM_CMP: begin
                o_op    = DP_REM_CMP;
                n_state = S_REM_DEL;
            end
            S_REM_DEL: begin
                if (i_stat.any_match) begin
                    o_op    = DP_REM_DEL;
                    n_state = S_REM_CMP;
                end else begin
                    n_state = S_REM_EMIT;
                end
            end
            S_REM_EMIT: begin
                if (i_stat.out_free) begin
                    o_op    = DP_EMIT_REM;
                    n_state = S_IDLE;
                end
            end
            S_DUMP: begin
                if (i_stat.out_free) begin
                    if (i_stat.empty) begin
                        o_op    = DP_EMIT_EMPTY;
                        n_state = S_IDLE;
                    end else begin
                        o_op = DP_DUMP_EMIT;
                        if (i_stat.dump_last) n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/dsdl_dpath.sv
// Slot registers, compare vectors, scan index and the output register.
// Depends on dsdl_pkg and dsdl_out_if.
module dsdl_dpath import dsdl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_op      i_op,
    input  logic [7:0]  i_handle,
    input  logic signed [15:0] i_depth_key,
    output t_dp_stat    o_stat,
    dsdl_out_if.source  o_out
);

    // list storage, shifted in place
    logic [7:0] r_hdl [CAPACITY];
    t_key       r_dep [CAPACITY];
    logic [7:0] n_hdl [CAPACITY];
    t_key       n_dep [CAPACITY];
    t_cnt       r_count, n_count;

    // per-operation work registers
    logic [7:0] r_op_hdl, n_op_hdl;
    t_key       r_op_key, n_op_key;
    t_vec       r_gt, n_gt;
    t_vec       r_match, n_match;
    logic       r_found, n_found;
    t_idx       r_first_pos, n_first_pos;
    t_key       r_first_dep, n_first_dep;
    t_idx       r_idx, n_idx;

    // output register
    logic        r_ov, n_ov;
    t_status     r_status, n_status;
    logic [7:0]  r_o_hdl, n_o_hdl;
    logic [15:0] r_o_dep, n_o_dep;
    logic [3:0]  r_o_pos, n_o_pos;
    logic        r_o_last, n_o_last;
    logic [4:0]  r_o_cnt, n_o_cnt;

    t_vec valid;
    t_cnt dump_n;
    t_idx at_idx;
    t_idx del_idx;
    logic out_free;

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) valid[i] = CNT_W'(i) < r_count;
        if (32'(r_count) > MAX_OUT) dump_n = CNT_W'(MAX_OUT);
        else                        dump_n = r_count;
    end

    assign at_idx   = first_set(~r_gt);
    assign del_idx  = first_set(r_match);
    assign out_free = !r_ov || o_out.ready;

    assign o_stat.full      = r_count == CNT_W'(CAPACITY);
    assign o_stat.empty     = r_count == '0;
    assign o_stat.any_match = |r_match;
    assign o_stat.dump_last = (CNT_W'(r_idx) + CNT_W'(1)) == dump_n;
    assign o_stat.out_free  = out_free;

    always_comb begin
        n_hdl       = r_hdl;
        n_dep       = r_dep;
        n_count     = r_count;
        n_op_hdl    = r_op_hdl;
        n_op_key    = r_op_key;
        n_gt        = r_gt;
        n_match     = r_match;
        n_found     = r_found;
        n_first_pos = r_first_pos;
        n_first_dep = r_first_dep;
        n_idx       = r_idx;
        n_ov        = r_ov && !o_out.ready;
        n_status    = r_status;
        n_o_hdl     = r_o_hdl;
        n_o_dep     = r_o_dep;
        n_o_pos     = r_o_pos;
        n_o_last    = r_o_last;
        n_o_cnt     = r_o_cnt;
        case (i_op)
            DP_LOAD: begin
                n_op_hdl    = i_handle;
                n_op_key    = sat_key(i_depth_key);
                n_idx       = '0;
                n_found     = 1'b0;
                n_first_pos = '0;
                n_first_dep = '0;
            end
            DP_INS_CMP: begin
                for (int i = 0; i < CAPACITY; i++) n_gt[i] = valid[i] && (r_dep[i] > r_op_key);
            end
            DP_INS_APPLY: begin
                for (int i = 1; i < CAPACITY; i++) begin
                    if (IDX_W'(i) > at_idx) begin
                        n_hdl[i] = r_hdl[i-1];
                        n_dep[i] = r_dep[i-1];
                    end
                end
                n_hdl[at_idx] = r_op_hdl;
                n_dep[at_idx] = r_op_key;
                n_count  = r_count + CNT_W'(1);
                n_ov     = 1'b1;
                n_status = ST_OK;
                n_o_hdl  = r_op_hdl;
                n_o_dep  = key_field(r_op_key);
                n_o_pos  = 4'(at_idx);
                n_o_last = 1'b1;
                n_o_cnt  = 5'(n_count);
            end
            DP_REM_CMP: begin
                for (int i = 0; i < CAPACITY; i++) n_match[i] = valid[i] && (r_hdl[i] == r_op_hdl);
            end
            DP_REM_DEL: begin
                // drop the lowest hit and pull the tail up by one
                for (int i = 0; i < CAPACITY - 1; i++) begin
                    if (IDX_W'(i) >= del_idx) begin
                        n_hdl[i] = r_hdl[i+1];
                        n_dep[i] = r_dep[i+1];
                    end
                end
                n_count = r_count - CNT_W'(1);
                n_match = '0;
                if (!r_found) begin
                    n_found     = 1'b1;
                    n_first_pos = del_idx;
                    n_first_dep = r_dep[del_idx];
                end
            end
            DP_EMIT_FULL: begin
                n_ov     = 1'b1;
                n_status = ST_FULL;
                n_o_hdl  = r_op_hdl;
                n_o_dep  = key_field(r_op_key);
                n_o_pos  = '0;
                n_o_last = 1'b1;
                n_o_cnt  = 5'(r_count);
            end
            DP_EMIT_REM: begin
                n_ov     = 1'b1;
                n_status = r_found ? ST_OK : ST_NOT_FOUND;
                n_o_hdl  = r_op_hdl;
                n_o_dep  = r_found ? key_field(r_first_dep) : '0;
                n_o_pos  = r_found ? 4'(r_first_pos) : '0;
                n_o_last = 1'b1;
                n_o_cnt  = 5'(r_count);
            end
            DP_DUMP_EMIT: begin
                n_ov     = 1'b1;
                n_status = ST_OK;
                n_o_hdl  = r_hdl[r_idx];
                n_o_dep  = key_field(r_dep[r_idx]);
                n_o_pos  = 4'(r_idx);
                n_o_last = o_stat.dump_last;
                n_o_cnt  = 5'(r_count);
                n_idx    = r_idx + IDX_W'(1);
            end
            DP_EMIT_EMPTY: begin
                n_ov     = 1'b1;
                n_status = ST_EMPTY;
                n_o_hdl  = '0;
                n_o_dep  = '0;
                n_o_pos  = '0;
                n_o_last = 1'b1;
                n_o_cnt  = 5'(r_count);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdl       <= n_hdl;
        r_dep       <= n_dep;
        r_op_hdl    <= n_op_hdl;
        r_op_key    <= n_op_key;
        r_gt        <= n_gt;
        r_match     <= n_match;
        r_found     <= n_found;
        r_first_pos <= n_first_pos;
        r_first_dep <= n_first_dep;
        r_idx       <= n_idx;
        r_status    <= n_status;
        r_o_hdl     <= n_o_hdl;
        r_o_dep     <= n_o_dep;
        r_o_pos     <= n_o_pos;
        r_o_last    <= n_o_last;
        r_o_cnt     <= n_o_cnt;
    end

    assign o_out.valid       = r_ov;
    assign o_out.status      = r_status;
    assign o_out.out_handle  = r_o_hdl;
    assign o_out.out_depth   = r_o_dep;
    assign o_out.position    = r_o_pos;
    assign o_out.last        = r_o_last;
    assign o_out.entry_count = r_o_cnt;

endmodule
